FILE: design/srcd_pkg.sv
// ----------------------------------------------------------------------------
// srcd_pkg - shared types and constants for the stepper ramp clock divider
// Register indexes, field widths and the word queued between front and back.
// ----------------------------------------------------------------------------
package srcd_pkg;

   localparam int WORD_BITS = 32;
   localparam int ACC_BITS  = 20;
   localparam int VEL_BITS  = 16;
   localparam int STEP_BITS = 16;
   localparam int CNT_BITS  = 24;
   localparam int IDX_BITS  = 2;

   localparam logic [IDX_BITS-1:0] REG_ACCEL = 2'd0;
   localparam logic [IDX_BITS-1:0] REG_VEL   = 2'd1;
   localparam logic [IDX_BITS-1:0] REG_CLOCK = 2'd2;
   localparam logic [IDX_BITS-1:0] REG_STEP  = 2'd3;

   localparam logic [WORD_BITS-1:0] BAND_LOW  = 32'd60;
   localparam logic [WORD_BITS-1:0] BAND_MID  = 32'd80;
   localparam logic [WORD_BITS-1:0] BAND_HIGH = 32'd240;

   localparam int QUEUE_DEPTH = 2;

   // classified word from front to back
   typedef struct packed {
      logic                 cruise;
      logic [CNT_BITS-1:0]  ramp_pos;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LEN1, ST_LEN2, ST_LEN3, ST_UNI, ST_RAMPQ, ST_RAMPM,
      ST_SQRT, ST_BAND, ST_DIV, ST_DONE
   } back_state_type;

endpackage

FILE: design/stepper_ramp_clock_divider.sv
// ----------------------------------------------------------------------------
// stepper_ramp_clock_divider - trapezoidal stepper step rate and clock divider
// Front stage queues commands; back stage sequences divisions and square root.
// ----------------------------------------------------------------------------
// Sequencing: the serial divider is used up to four times per word, and the
//    square root is added for ramp words inside the ramp.
// Queueing: a two-entry queue takes new request words while the back stage
//    works and while a response word waits, as long as it is not full.
// Reset: synchronous, active high; state and config registers are reset.
module stepper_ramp_clock_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // steps_from_start[23:0], steps_to_end[47:24]
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // step_frequency[31:0], clock_divider[63:32]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import srcd_pkg::*;

   logic [ACC_BITS-1:0]  accel_ff;
   logic [VEL_BITS-1:0]  vel_ff;
   logic [WORD_BITS-1:0] clk_ff;
   logic [STEP_BITS-1:0] step_ff;
   logic                 cmd_valid, cmd_ready;
   cmd_type              cmd;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff <= '0;
         vel_ff   <= '0;
         clk_ff   <= 32'd1000000;
         step_ff  <= STEP_BITS'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_ACCEL: accel_ff <= csr_data[ACC_BITS-1:0];
            REG_VEL:   vel_ff   <= csr_data[VEL_BITS-1:0];
            REG_CLOCK: clk_ff   <= csr_data;
            REG_STEP:  step_ff  <= csr_data[STEP_BITS-1:0];
            default:   ;
         endcase
      end
   end

   srcd_front u_front (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .req_tdata(req_tdata), .req_tuser(req_tuser),
      .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
   );

   srcd_back u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid),
      .cmd_ready(cmd_ready), .cmd(cmd), .accel(accel_ff), .vel(vel_ff),
      .clk_freq(clk_ff), .step(step_ff), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

`ifndef NO_ASSERTIONS
   a_clock_reg_reset: assert property (@(posedge clock)
      $fell(reset) |-> clk_ff == 32'd1000000)
      else $error("clock register lost reset value");
   a_cmd_flow: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && cmd_ready) |=> !cmd_ready) else $error("back took two commands");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("response word changed while stalled");
`endif

endmodule

FILE: design/srcd_divider.sv
// ----------------------------------------------------------------------------
// srcd_divider - iterative unsigned divider
// Restoring division, one quotient bit per cycle; zero divisor gives all ones.
// ----------------------------------------------------------------------------
module srcd_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [srcd_pkg::WORD_BITS-1:0] dividend,
   input  logic [srcd_pkg::WORD_BITS-1:0] divisor,
   output logic                           done,
   output logic [srcd_pkg::WORD_BITS-1:0] quotient
);
   import srcd_pkg::*;

   localparam int CB = $clog2(WORD_BITS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CB-1:0]        count_ff, count_in;
   logic [WORD_BITS-1:0] quot_ff, quot_in;
   logic [WORD_BITS-1:0] div_ff, div_in;
   logic [WORD_BITS:0]   rem_ff, rem_in;
   logic [WORD_BITS:0]   trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quot_in  = quot_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      trial    = {rem_ff[WORD_BITS-1:0], quot_ff[WORD_BITS-1]};
      if (start) begin
         busy_in  = 1'b1;
         count_in = CB'(WORD_BITS);
         quot_in  = dividend;
         div_in   = divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         quot_in = {quot_ff[WORD_BITS-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in     = trial - {1'b0, div_ff};
            quot_in[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CB'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
   end

   assign done     = done_ff;
   // division by zero in restoring form already yields all ones
   assign quotient = quot_ff;

`ifndef NO_ASSERTIONS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider restarted while busy");
   a_busy_ends: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> done_ff) else $error("divider stopped without done");
`endif

endmodule

FILE: design/srcd_front.sv
// ----------------------------------------------------------------------------
// srcd_front - input stage and command queue
// Takes request words, forms the ramp position and queues the command.
// ----------------------------------------------------------------------------
module srcd_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [srcd_pkg::CNT_BITS*2-1:0] req_tdata,
   input  logic                           req_tuser,
   output logic                           cmd_valid,
   input  logic                           cmd_ready,
   output srcd_pkg::cmd_type              cmd
);
   import srcd_pkg::*;

   cmd_type            queue_ff [QUEUE_DEPTH];
   logic               wr_ptr_ff, rd_ptr_ff;
   logic [1:0]         fill_ff, fill_in;
   logic [CNT_BITS-1:0] from_v, to_v;
   cmd_type            new_cmd;
   logic               push, pop;

   assign from_v  = req_tdata[CNT_BITS-1:0];
   assign to_v    = req_tdata[2*CNT_BITS-1:CNT_BITS];
   assign new_cmd.cruise   = req_tuser;
   assign new_cmd.ramp_pos = (from_v <= to_v) ? from_v : to_v;

   assign req_tready = (fill_ff != 2'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (fill_ff != 2'd0);
   assign pop        = cmd_valid && cmd_ready;
   assign cmd        = queue_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      case ({push, pop})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         fill_ff <= fill_in;
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
      end
      if (push) queue_ff[wr_ptr_ff] <= new_cmd;
   end

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 2'(QUEUE_DEPTH)) else $error("queue overfilled");
   a_fill_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> fill_ff == $past(fill_ff) + 2'd1)
      else $error("queue count lost a push");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'd0 || fill_ff == 2'd2) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers out of step");
`endif

endmodule

FILE: design/srcd_back.sv
// ----------------------------------------------------------------------------
// srcd_back - frequency and divider sequencer
// Works one command through a shared divider, square root and band rules.
// ----------------------------------------------------------------------------
module srcd_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   output logic                            cmd_ready,
   input  srcd_pkg::cmd_type               cmd,
   input  logic [srcd_pkg::ACC_BITS-1:0]   accel,
   input  logic [srcd_pkg::VEL_BITS-1:0]   vel,
   input  logic [srcd_pkg::WORD_BITS-1:0]  clk_freq,
   input  logic [srcd_pkg::STEP_BITS-1:0]  step,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [2*srcd_pkg::WORD_BITS-1:0] rsp_tdata
);
   import srcd_pkg::*;

   localparam int SQB = $clog2(WORD_BITS/2 + 1);

   back_state_type        state_ff, state_in;
   cmd_type               cmd_ff;
   logic [WORD_BITS-1:0]  t_ff, t_in;
   logic [WORD_BITS-1:0]  f_ff, f_in;
   logic [WORD_BITS-1:0]  len_ff, len_in;
   logic [WORD_BITS-1:0]  sx_ff, sx_in, sr_ff, sr_in, sb_ff, sb_in;
   logic [SQB-1:0]        sc_ff, sc_in;
   logic                  out_valid_ff;
   logic [WORD_BITS-1:0]  out_f_ff, out_d_ff;
   logic                  div_start;
   logic [WORD_BITS-1:0]  div_a, div_b, div_q;
   logic                  div_done;
   logic                  take, degen, in_ramp;
   logic [WORD_BITS-1:0]  prod, step_w, sq_sum;

   srcd_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_a),
      .divisor(div_b), .done(div_done), .quotient(div_q)
   );

   assign degen     = (step == '0) || (accel == '0);
   assign step_w    = WORD_BITS'(step);
   assign cmd_ready = (state_ff == ST_IDLE);
   assign take      = cmd_valid && cmd_ready;
   assign sq_sum    = sr_ff + sb_ff;
   assign in_ramp   = (WORD_BITS'(cmd_ff.ramp_pos) <= len_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (take) begin
            if (cmd.cruise) state_in = ST_UNI;
            else if (degen) state_in = cmd.ramp_pos == '0 ? ST_BAND : ST_UNI;
            else state_in = ST_LEN1;
         end
         ST_LEN1:  if (div_done) state_in = ST_LEN2;
         ST_LEN2:  if (div_done) state_in = ST_LEN3;
         ST_LEN3:  state_in = in_ramp ? ST_RAMPQ : ST_UNI;
         ST_UNI:   if (div_done || step == '0)
            state_in = cmd_ff.cruise ? ST_DIV : ST_BAND;
         ST_RAMPQ: if (div_done) state_in = ST_RAMPM;
         ST_RAMPM: state_in = ST_SQRT;
         ST_SQRT:  if (sc_ff == '0) state_in = ST_BAND;
         ST_BAND:  state_in = ST_DIV;
         ST_DIV:   if (div_done || clk_freq == '0) state_in = ST_DONE;
         ST_DONE:  if (!out_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and divider control
   always_comb begin
      div_start = 1'b0;
      div_a     = '0;
      div_b     = '0;
      t_in      = t_ff;
      f_in      = f_ff;
      len_in    = len_ff;
      sx_in     = sx_ff;
      sr_in     = sr_ff;
      sb_in     = sb_ff;
      sc_in     = sc_ff;
      prod      = '0;
      unique case (state_ff)
         ST_IDLE: if (take) begin
            f_in = WORD_BITS'(1);
            if (cmd.cruise || degen) begin
               if (!(degen && !cmd.cruise && cmd.ramp_pos == '0)) begin
                  div_start = (step != '0);
                  div_a     = WORD_BITS'(32'd1000 * WORD_BITS'(vel));
                  div_b     = step_w;
               end
            end else begin
               div_start = 1'b1;
               div_a     = WORD_BITS'(vel) * WORD_BITS'(vel);
               div_b     = WORD_BITS'(accel);
            end
         end
         ST_LEN1: if (div_done) begin
            div_start = 1'b1;
            div_a     = WORD_BITS'(div_q * WORD_BITS'(1000));
            div_b     = WORD_BITS'(step_w << 1);
         end
         ST_LEN2: if (div_done) begin
            len_in = div_q;
         end
         // inside the ramp: 2000*a/step, else the uniform rate
         ST_LEN3: begin
            div_start = 1'b1;
            div_b     = step_w;
            if (in_ramp) div_a = WORD_BITS'(32'd2000 * WORD_BITS'(accel));
            else div_a = WORD_BITS'(32'd1000 * WORD_BITS'(vel));
         end
         ST_UNI: if (div_done) f_in = div_q;
         ST_RAMPQ: if (div_done) t_in = div_q;
         ST_RAMPM: begin
            prod  = WORD_BITS'(t_ff * (WORD_BITS'(cmd_ff.ramp_pos) + WORD_BITS'(1)));
            sx_in = prod;
            sr_in = '0;
            sb_in = WORD_BITS'(1) << (WORD_BITS - 2);
            sc_in = SQB'(WORD_BITS/2);
         end
         ST_SQRT: if (sc_ff != '0) begin
            if (sx_ff >= sq_sum) begin
               sx_in = sx_ff - sq_sum;
               sr_in = (sr_ff >> 1) + sb_ff;
            end else begin
               sr_in = sr_ff >> 1;
            end
            sb_in = sb_ff >> 2;
            sc_in = sc_ff - 1'b1;
         end else begin
            f_in = sr_ff;
         end
         ST_BAND: begin
            if (f_ff > BAND_MID && f_ff < BAND_HIGH) f_in = BAND_HIGH;
            else if (f_ff < BAND_LOW) f_in = BAND_LOW;
            div_start = (clk_freq != '0);
            div_a     = clk_freq;
         end
         ST_DIV: ;
         ST_DONE: ;
         default: ;
      endcase
      // leaving UNI for cruise or BAND for ramp: clamp and start the divider
      if (state_ff == ST_UNI && (div_done || step == '0) && cmd_ff.cruise) begin
         if (step != '0) f_in = div_q;
         div_start = (clk_freq != '0);
         div_a     = clk_freq;
      end
      if (div_start && (state_ff == ST_BAND || (state_ff == ST_UNI && cmd_ff.cruise)))
      begin
         if (f_in == '0) f_in = WORD_BITS'(1);
         else if (f_in > clk_freq) f_in = clk_freq;
         div_b = f_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && (!out_valid_ff || rsp_tready))
            out_valid_ff <= 1'b1;
         else if (rsp_tready)
            out_valid_ff <= 1'b0;
      end
      if (take) cmd_ff <= cmd;
      t_ff   <= t_in;
      f_ff   <= f_in;
      len_ff <= len_in;
      sx_ff  <= sx_in;
      sr_ff  <= sr_in;
      sb_ff  <= sb_in;
      sc_ff  <= sc_in;
      if (state_ff == ST_DONE && (!out_valid_ff || rsp_tready)) begin
         if (clk_freq == '0) begin
            out_f_ff <= WORD_BITS'(1);
            out_d_ff <= '0;
         end else begin
            out_f_ff <= f_ff;
            out_d_ff <= div_q;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_d_ff, out_f_ff};

`ifndef NO_ASSERTIONS
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      take |=> state_ff != ST_IDLE) else $error("command taken but idle");
   a_freq_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[WORD_BITS-1:0] != '0) else $error("zero frequency");
   a_div_start_clean: assert property (@(posedge clock) disable iff (reset)
      div_start |=> !div_done) else $error("divider done too early");
`endif

endmodule
